// ===== src/s3c_pkg.sv =====
// shared constants for the 3x3 convolution unit
`timescale 1ns / 1ps
package s3c_pkg;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int COEF_BITS_DEF = 11;
    localparam int PIX_W = 16;
    localparam int ROW_W = 16;
    localparam int COL_W = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER = 3'd4;
    localparam logic [12:0] WIDTH_RST = 13'd640;
    localparam logic [15:0] HEIGHT_RST = 16'd480;
    localparam logic [15:0] PIX_MAX = 16'hFFFF;
endpackage

// ===== src/s3c_pix_if.sv =====
// valid/ready channel carrying one input pixel
`timescale 1ns / 1ps
interface s3c_pix_if;
    logic                       valid;
    logic                       ready;
    logic [s3c_pkg::PIX_W-1:0]  pixel_in;
    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

// ===== src/s3c_res_if.sv =====
// valid/ready channel carrying one result pixel
`timescale 1ns / 1ps
interface s3c_res_if;
    logic                       valid;
    logic                       ready;
    logic [s3c_pkg::PIX_W-1:0]  pixel_out;
    logic [s3c_pkg::ROW_W-1:0]  out_row;
    logic [s3c_pkg::COL_W-1:0]  out_col;
    logic                       last_of_item;
    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output last_of_item, input ready);
    modport sink (input valid, input pixel_out, input out_row, input out_col,
                  input last_of_item, output ready);
endinterface

// ===== src/s3c_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with stall
`timescale 1ns / 1ps
module s3c_div #(
    parameter int NW = 48,
    parameter int DW = 16,
    parameter int TW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);
    logic [NW-1:0] r_q [NW+1];
    logic [DW-1:0] r_r [NW+1];
    logic [DW-1:0] r_d [NW+1];
    logic [TW-1:0] r_t [NW+1];
    logic          r_v [NW+1];

    always_comb begin
        r_q[0] = i_num;
        r_r[0] = '0;
        r_d[0] = i_den;
        r_t[0] = i_tag;
        r_v[0] = i_valid;
    end

    for (genvar s = 0; s < NW; s++) begin : g_st
        logic [DW:0] n_rem;
        logic [DW:0] n_dif;
        always_comb begin
            n_rem = {r_r[s], r_q[s][NW-1]};
            n_dif = n_rem - {1'b0, r_d[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
            if (i_en) begin
                r_d[s+1] <= r_d[s];
                r_t[s+1] <= r_t[s];
                if (!n_dif[DW]) begin
                    r_r[s+1] <= n_dif[DW-1:0];
                    r_q[s+1] <= {r_q[s][NW-2:0], 1'b1};
                end else begin
                    r_r[s+1] <= n_rem[DW-1:0];
                    r_q[s+1] <= {r_q[s][NW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[NW];
    assign o_quo   = r_q[NW];
    assign o_tag   = r_t[NW];
endmodule

// ===== src/symmetric_3x3_image_convolution_unit.sv =====
// top level of the symmetric 3x3 convolution unit
`timescale 1ns / 1ps
// throughput: one pixel per cycle while the output slot is free and each pixel causes
// at most one result; a pixel causing two results (interior plus border) holds input
// until its second result is loaded into the output register; the pipeline moves as a
// whole when its output slot is free and no second result is pending; stalls lose nothing
// reset (i_rst_n low, synchronous) clears counters, window, valids and registers
// to their preset values; line stores are not cleared
module symmetric_3x3_image_convolution_unit #(
    parameter int MAX_WIDTH = s3c_pkg::MAX_WIDTH_DEF,
    parameter int COEF_BITS = s3c_pkg::COEF_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [s3c_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [s3c_pkg::CFG_DATA_W-1:0] i_cfg_data,
    s3c_pix_if.sink                       pix_in,
    s3c_res_if.source                     res_out
);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int SW  = 16 + 3 + COEF_BITS + 1;   // product sum width, signed
    localparam int DW  = COEF_BITS + 3;            // weight sum magnitude
    localparam int NW  = SW - 1;                   // nonneg numerator bits
    localparam int TW  = 2 + 16 + 16 + 12 + 1;     // tag: kinds, border px, row, col, neg

    // configuration registers
    logic [12:0]          r_width;
    logic [15:0]          r_height;
    logic [COEF_BITS-1:0] r_cw, r_ew, r_kw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= s3c_pkg::WIDTH_RST;
            r_height <= s3c_pkg::HEIGHT_RST;
            r_cw     <= COEF_BITS'(44);
            r_ew     <= COEF_BITS'(-1);
            r_kw     <= COEF_BITS'(-2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                s3c_pkg::REG_WIDTH:  r_width  <= i_cfg_data[12:0];
                s3c_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                s3c_pkg::REG_CENTRE: r_cw     <= i_cfg_data[COEF_BITS-1:0];
                s3c_pkg::REG_EDGE:   r_ew     <= i_cfg_data[COEF_BITS-1:0];
                s3c_pkg::REG_CORNER: r_kw     <= i_cfg_data[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    logic [14:0] w_eff;
    logic [16:0] h_eff;
    always_comb begin
        w_eff = {2'b0, r_width};
        if (r_width == '0) w_eff = 15'd1;
        if (w_eff > 15'(MAX_WIDTH)) w_eff = 15'(MAX_WIDTH);
        h_eff = (r_height == '0) ? 17'd1 : {1'b0, r_height};
    end

    // weight sum (constant between frames)
    logic signed [DW:0] w_sum;
    logic [DW-1:0]      w_den;
    always_comb begin
        w_sum = (DW+1)'($signed(r_cw)) + ((DW+1)'($signed(r_ew)) + (DW+1)'($signed(r_kw))) * 4;
        if (w_sum == '0) w_den = DW'(1);
        else if (w_sum[DW]) w_den = DW'(-w_sum);
        else w_den = w_sum[DW-1:0];
    end

    // pipeline enable: everything moves when the output slot can take data and no second result is pending
    logic en;
    logic r_ov;
    logic r_hold;   // second result of a double item pending

    // stage 0: input, counters, line store access
    logic [PIXB-1:0] dummy_unused;
    localparam int PIXB = 1;
    assign dummy_unused = '0;

    logic [15:0] r_row;
    logic [12:0] r_col;
    logic [15:0] mem_prev [MAX_WIDTH];
    logic [15:0] mem_old  [MAX_WIDTH];
    logic        acc;
    assign acc = pix_in.valid & pix_in.ready;
    assign pix_in.ready = en;

    logic [AW-1:0] idx;
    assign idx = AW'(r_col);

    // stage 1 registers
    logic        r1_v;
    logic [15:0] r1_px, r1_u1, r1_u2;
    logic        r1_int, r1_bor;
    logic [15:0] r1_row;
    logic [11:0] r1_col;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            mem_prev[idx] <= pix_in.pixel_in;
            mem_old[idx]  <= mem_prev[idx];
        end
        if (en) begin
            r1_u1  <= mem_prev[idx];
            r1_u2  <= mem_old[idx];
            r1_px  <= pix_in.pixel_in;
            r1_row <= r_row;
            r1_col <= r_col[11:0];
            r1_int <= (r_row >= 16'd2) && (r_col >= 13'd2) && ({1'b0, r_row} < h_eff)
                      && ({2'b0, r_col} < w_eff);
            r1_bor <= (r_row == '0) || (r_col == '0) || ({1'b0, r_row} + 17'd1 >= h_eff)
                      || ({2'b0, r_col} + 15'd1 >= w_eff);
        end
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r1_v  <= 1'b0;
        end else if (en) begin
            r1_v <= acc;
            if (acc) begin
                if ({2'b0, r_col} + 15'd1 >= w_eff) begin
                    r_col <= '0;
                    r_row <= ({1'b0, r_row} + 17'd1 >= h_eff) ? '0 : r_row + 16'd1;
                end else begin
                    r_col <= r_col + 13'd1;
                end
            end
        end
    end

    // stage 2: window shift and neighbour sums
    logic [15:0] r_win [6];
    logic        r2_v;
    logic [17:0] r2_diag, r2_orth;
    logic [15:0] r2_mid, r2_px;
    logic        r2_int, r2_bor;
    logic [15:0] r2_row;
    logic [11:0] r2_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else if (en) begin
            r2_v <= r1_v;
            if (r1_v) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= r1_u2;
                r_win[4] <= r1_u1;
                r_win[5] <= r1_px;
            end
        end
        if (en) begin
            r2_diag <= 18'(r_win[0]) + 18'(r1_u2) + 18'(r_win[2]) + 18'(r1_px);
            r2_orth <= 18'(r_win[3]) + 18'(r_win[1]) + 18'(r1_u1) + 18'(r_win[5]);
            r2_mid  <= r_win[4];
            r2_px   <= r1_px;
            r2_int  <= r1_int;
            r2_bor  <= r1_bor;
            r2_row  <= r1_row;
            r2_col  <= r1_col;
        end
    end

    // stage 3: products
    logic               r3_v;
    logic signed [SW-1:0] r3_pk, r3_pe, r3_pc;
    logic [15:0] r3_px;
    logic        r3_int, r3_bor;
    logic [15:0] r3_row;
    logic [11:0] r3_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= r2_v;
        if (en) begin
            r3_pk  <= SW'($signed({1'b0, r2_diag}) * $signed(r_kw));
            r3_pe  <= SW'($signed({1'b0, r2_orth}) * $signed(r_ew));
            r3_pc  <= SW'($signed({1'b0, r2_mid}) * $signed(r_cw));
            r3_px  <= r2_px;
            r3_int <= r2_int;
            r3_bor <= r2_bor;
            r3_row <= r2_row;
            r3_col <= r2_col;
        end
    end

    // stage 4: sum
    logic                 r4_v;
    logic signed [SW-1:0] r4_f;
    logic [15:0] r4_px;
    logic        r4_int, r4_bor;
    logic [15:0] r4_row;
    logic [11:0] r4_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
        if (en) begin
            r4_f   <= r3_pk + r3_pe + r3_pc;
            r4_px  <= r3_px;
            r4_int <= r3_int;
            r4_bor <= r3_bor;
            r4_row <= r3_row;
            r4_col <= r3_col;
        end
    end

    // divider by the weight magnitude
    logic          dv_v;
    logic [NW-1:0] dv_q;
    logic [TW-1:0] dv_t, tag_in;
    assign tag_in = {r4_int, r4_bor, r4_px, r4_row, r4_col, r4_f[SW-1]};

    s3c_div #(.NW(NW), .DW(DW), .TW(TW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_num   (r4_f[NW-1:0]),
        .i_den   (w_den),
        .i_tag   (tag_in),
        .o_valid (dv_v),
        .o_quo   (dv_q),
        .o_tag   (dv_t)
    );

    // result formation
    logic        t_int, t_bor, t_neg;
    logic [15:0] t_px, t_row;
    logic [11:0] t_col;
    logic        wneg;
    logic [NW:0] sq;
    logic [15:0] fval;
    assign {t_int, t_bor, t_px, t_row, t_col, t_neg} = dv_t;
    assign wneg = (w_sum < 0);
    always_comb begin
        sq = wneg ? (NW+1)'(-{1'b0, dv_q}) : {1'b0, dv_q};
        if (t_neg) fval = '0;
        else if (!wneg && dv_q > NW'(s3c_pkg::PIX_MAX)) fval = s3c_pkg::PIX_MAX;
        else fval = sq[15:0];
    end

    // output register; a double item holds the pipeline until its second result is loaded
    logic [15:0] r_opx, r_orow;
    logic [11:0] r_ocol;
    logic        r_olast;
    logic [15:0] r_hpx, r_hrow;
    logic [11:0] r_hcol;
    logic        slot_free;
    assign slot_free = !r_ov || res_out.ready;
    assign en = slot_free && !r_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_hold <= 1'b0;
        end else if (slot_free) begin
            if (r_hold) begin
                r_ov   <= 1'b1;
                r_hold <= 1'b0;
            end else begin
                r_ov   <= dv_v && (t_int || t_bor);
                r_hold <= dv_v && t_int && t_bor;
            end
        end
        if (slot_free) begin
            if (r_hold) begin
                r_opx   <= r_hpx;
                r_orow  <= r_hrow;
                r_ocol  <= r_hcol;
                r_olast <= 1'b1;
            end else begin
                r_opx   <= t_int ? fval : t_px;
                r_orow  <= t_int ? t_row - 16'd1 : t_row;
                r_ocol  <= t_int ? t_col - 12'd1 : t_col;
                r_olast <= !(t_int && t_bor);
                r_hpx   <= t_px;
                r_hrow  <= t_row;
                r_hcol  <= t_col;
            end
        end
    end

    assign res_out.valid        = r_ov;
    assign res_out.pixel_out    = r_opx;
    assign res_out.out_row      = r_orow;
    assign res_out.out_col      = r_ocol;
    assign res_out.last_of_item = r_olast;

    a_hold_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold |-> r_ov) else $error("pending second result without first");
    a_no_accept_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold |-> !pix_in.ready) else $error("input taken during second result");
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !res_out.ready) |=> r_ov) else $error("result dropped under stall");
endmodule

// ===== verif/symmetric_3x3_image_convolution_unit_test.sv =====
// self-checking testbench for the symmetric 3x3 convolution unit
`timescale 1ns / 1ps
module symmetric_3x3_image_convolution_unit_test;
    import s3c_pkg::*;

    localparam int LINE_DEPTH = 4096;
    localparam int STALL_LIMIT = 5000;   // cycles with no request moving on either side
    localparam int DRAIN_CYCLES = 50;    // a little over the pipeline latency

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } pixel_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    s3c_pix_if pix_ch ();
    s3c_res_if res_ch ();

    symmetric_3x3_image_convolution_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .pix_in     (pix_ch.sink),
        .res_out    (res_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // mirror of the filter state, updated on every accepted request
    logic [PIX_W-1:0]  prev_line [LINE_DEPTH];
    logic [PIX_W-1:0]  older_line [LINE_DEPTH];
    logic [PIX_W-1:0]  window [6];   // 0..2 column c-2 top..bottom, 3..5 column c-1
    int unsigned       row_cnt;
    int unsigned       col_cnt;
    logic [12:0]       cfg_width;
    logic [15:0]       cfg_height;
    logic signed [10:0] w_centre;
    logic signed [10:0] w_edge;
    logic signed [10:0] w_corner;

    pixel_result_t expected_pixels [$];
    int            error_count = 0;
    bit            no_idle = 0;     // both sides run flat out while set
    int            rx_hold = 0;     // one-off long receiver stall, in cycles
    int            quiet_cycles = 0;

    // effective frame size: zero acts as one, width clipped to the line store depth
    function automatic int unsigned frame_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
        return cfg_width;
    endfunction

    function automatic int unsigned frame_height();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    // weighted mask sum over the 3x3 neighbourhood, normalised and clamped
    function automatic logic [PIX_W-1:0] convolve(input logic [PIX_W-1:0] t0, t1, t2,
                                                  m0, m1, m2, b0, b1, b2);
        longint c_w;
        longint e_w;
        longint k_w;
        longint wsum;
        longint diag;
        longint orth;
        longint acc;
        longint quot;
        c_w = w_centre;
        e_w = w_edge;
        k_w = w_corner;
        wsum = c_w + 4 * (e_w + k_w);
        diag = longint'(t0) + t2 + b0 + b2;
        orth = longint'(t1) + m0 + m2 + b1;
        acc = k_w * diag + e_w * orth + c_w * longint'(m1);
        if (wsum == 0) wsum = 1;
        if (acc < 0) return '0;
        quot = acc / wsum;   // truncates toward zero
        if (quot > 65535) return PIX_MAX;
        return quot[15:0];
    endfunction

    // queue the results caused by one accepted pixel and advance the state
    task automatic predict_pixel(input logic [PIX_W-1:0] px);
        int unsigned   w;
        int unsigned   h;
        int unsigned   r;
        int unsigned   c;
        int unsigned   idx;
        logic [PIX_W-1:0] up2;
        logic [PIX_W-1:0] up1;
        pixel_result_t res [2];
        int            n;
        w = frame_width();
        h = frame_height();
        r = row_cnt;
        c = col_cnt;
        idx = c % LINE_DEPTH;
        up2 = older_line[idx];
        up1 = prev_line[idx];
        n = 0;
        // interior pixel one row up and one column left is now complete
        if (r >= 2 && c >= 2 && r < h && c < w) begin
            res[n].pix = convolve(window[0], window[3], up2, window[1], window[4], up1,
                                  window[2], window[5], px);
            res[n].row = ROW_W'(r - 1);
            res[n].col = COL_W'(c - 1);
            res[n].last = 1'b0;
            n++;
        end
        // border pixels go straight through
        if (r == 0 || c == 0 || r + 1 >= h || c + 1 >= w) begin
            res[n].pix = px;
            res[n].row = ROW_W'(r);
            res[n].col = COL_W'(c);
            res[n].last = 1'b0;
            n++;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_pixels.push_back(res[i]);
        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = up2;
        window[4] = up1;
        window[5] = px;
        older_line[idx] = up1;
        prev_line[idx] = px;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_cnt = c;
        row_cnt = r;
    endtask

    // one register write, applied to the mirror at the same edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width = data[12:0];
            REG_HEIGHT: cfg_height = data;
            REG_CENTRE: w_centre = data[10:0];
            REG_EDGE:   w_edge = data[10:0];
            REG_CORNER: w_corner = data[10:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input int width, input int height, input int centre,
                             input int edge_w, input int corner);
        write_reg(REG_WIDTH, CFG_DATA_W'(width));
        write_reg(REG_HEIGHT, CFG_DATA_W'(height));
        write_reg(REG_CENTRE, CFG_DATA_W'(centre));
        write_reg(REG_EDGE, CFG_DATA_W'(edge_w));
        write_reg(REG_CORNER, CFG_DATA_W'(corner));
    endtask

    // sender pauses until every result is in and the pipeline has drained
    task automatic wait_idle();
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // offer one request and wait for it to be taken
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_in <= px;
        do @(posedge i_clk); while (pix_ch.ready !== 1'b1);
        predict_pixel(px);
    endtask

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return PIX_MAX;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // whole frames only, so the counters are back at the origin afterwards
    task automatic send_frame();
        int unsigned total;
        total = frame_width() * frame_height();
        for (int unsigned i = 0; i < total; i++) send_pixel(random_pixel());
        pix_ch.valid <= 1'b0;
    endtask

    task automatic test_preset_frame();
        // only the size changes, weights stay at the sharpen preset
        write_reg(REG_WIDTH, 16'd5);
        write_reg(REG_HEIGHT, 16'd4);
        for (int i = 0; i < 20; i++)
            send_pixel((i % 3 == 0) ? PIX_MAX : (i % 3 == 1) ? 16'h0000 : PIX_W'(i * 1000));
        pix_ch.valid <= 1'b0;
        wait_idle();
    endtask

    task automatic test_degenerate_sizes();
        // zero width and height act as one; frames below 3x3 are all border
        set_frame(0, 0, 44, -1, -2);
        send_frame();
        wait_idle();
        set_frame(2, 2, 44, -1, -2);
        send_frame();
        wait_idle();
        set_frame(1, 3, 44, -1, -2);
        send_frame();
        wait_idle();
        set_frame(3, 1, 44, -1, -2);
        send_frame();
        wait_idle();
        set_frame(3, 3, 44, -1, -2);
        send_frame();
        wait_idle();
    endtask

    task automatic test_weight_extremes();
        // overflow clamp, negative sum, zero weight, negative weight sum
        set_frame(5, 4, 1023, 1023, 1023);
        send_frame();
        wait_idle();
        set_frame(4, 5, -1024, -1024, -1024);
        send_frame();
        wait_idle();
        set_frame(6, 4, 0, 0, 0);
        send_frame();
        wait_idle();
        set_frame(5, 5, 1023, -1024, 0);
        send_frame();
        wait_idle();
        set_frame(4, 4, 0, 1, 0);
        send_frame();
        wait_idle();
    endtask

    task automatic test_full_width();
        // width above the line store depth is clipped to it
        no_idle = 1;
        set_frame(8191, 3, 44, -1, -2);
        send_frame();
        wait_idle();
        no_idle = 0;
    endtask

    task automatic test_full_height();
        // single column of the tallest frame, every pixel on the border
        no_idle = 1;
        set_frame(1, 65535, 44, -1, -2);
        send_frame();
        wait_idle();
        no_idle = 0;
    endtask

    task automatic test_backpressure();
        // receiver holds off long enough for the input side to back up
        set_frame(8, 8, 44, -1, -2);
        rx_hold = 400;
        no_idle = 1;
        send_frame();
        no_idle = 0;
        wait_idle();
    endtask

    task automatic test_random_frames();
        int sent;
        int w;
        int h;
        sent = 0;
        while (sent < 400) begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 10);
            case ($urandom_range(0, 3))
                0: set_frame(w, h, 44, -1, -2);
                1: set_frame(w, h, $urandom_range(0, 40), $urandom_range(0, 6),
                             $urandom_range(0, 6));
                default: set_frame(w, h, $urandom_range(0, 2047), $urandom_range(0, 2047),
                                   $urandom_range(0, 2047));
            endcase
            no_idle = ($urandom_range(0, 4) == 0);
            send_frame();
            sent += w * h;
            wait_idle();
        end
        no_idle = 0;
    endtask

    // receiver: random stalls, then compare each accepted result
    initial begin
        int gap;
        pixel_result_t exp_res;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                res_ch.ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid === 1'b1 && res_ch.ready === 1'b1));
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result pix=%h row=%0d col=%0d", $time,
                         res_ch.pixel_out, res_ch.out_row, res_ch.out_col);
                error_count++;
            end else begin
                exp_res = expected_pixels.pop_front();
                if (res_ch.pixel_out !== exp_res.pix) begin
                    $display("%0t: pixel_out expected %h actual %h", $time,
                             exp_res.pix, res_ch.pixel_out);
                    error_count++;
                end
                if (res_ch.out_row !== exp_res.row) begin
                    $display("%0t: out_row expected %0d actual %0d", $time,
                             exp_res.row, res_ch.out_row);
                    error_count++;
                end
                if (res_ch.out_col !== exp_res.col) begin
                    $display("%0t: out_col expected %0d actual %0d", $time,
                             exp_res.col, res_ch.out_col);
                    error_count++;
                end
                if (res_ch.last_of_item !== exp_res.last) begin
                    $display("%0t: last_of_item expected %b actual %b", $time,
                             exp_res.last, res_ch.last_of_item);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles where no request moves
    always @(posedge i_clk) begin
        if ((pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (i_rst_n === 1'b1) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_WIDTH;
        i_cfg_data <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel_in <= '0;
        row_cnt = 0;
        col_cnt = 0;
        for (int i = 0; i < 6; i++) window[i] = '0;
        cfg_width = WIDTH_RST;
        cfg_height = HEIGHT_RST;
        w_centre = 11'sd44;
        w_edge = -11'sd1;
        w_corner = -11'sd2;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_preset_frame();
        test_degenerate_sizes();
        test_weight_extremes();
        test_backpressure();
        test_full_width();
        test_full_height();
        test_random_frames();

        // anything still queued after the drain never arrived
        wait_idle();
        if (expected_pixels.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== symmetric_3x3_image_convolution_unit.f =====
src/s3c_pkg.sv
src/s3c_pix_if.sv
src/s3c_res_if.sv
src/s3c_div.sv
src/symmetric_3x3_image_convolution_unit.sv
verif/symmetric_3x3_image_convolution_unit_test.sv
